@@ src/pxb_pkg.sv @@
`default_nettype none

package pxb_pkg;

    localparam int NUM_CH = 3;
    localparam int CH_W = 8;
    localparam int PROD_W = 2 * CH_W;
    localparam int RECIP_W = PROD_W;
    localparam int SCALE_W = PROD_W + RECIP_W;

    localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'(255 * 255);
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(127);
    // ceil(2^23 / 255), exact quotient for every 16-bit dividend
    localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'(32897);
    localparam int RECIP_SHIFT = 23;

    typedef enum logic [1:0] {
        MODE_MULTIPLY = 2'd0,
        MODE_SUBTRACT = 2'd1,
        MODE_SCREEN   = 2'd2,
        MODE_OVERLAY  = 2'd3
    } blend_mode_t;

endpackage

`default_nettype wire

@@ src/pixel_layer_blend.sv @@
// channel | handshake              | payload
// --------+------------------------+---------------------------------------------
// in      | in_valid / in_stall    | base_red/green/blue, top_red/green/blue
// out     | out_valid / out_stall  | out_red, out_green, out_blue
// cfg     | cfg_valid / cfg_ready  | cfg_data (blend_mode, 2 bits)
//
// one word per clock while out_stall does not freeze the pipeline; an accepted word passes through
// the stage 1, 2 and 3 registers and the output register before out_valid. stages: operand select and
// multiply, scale and round bias, reciprocal multiply, result select into the output register
// rst_n clears all valid bits and sets blend_mode to multiply
// out_stall freezes the whole pipeline only while the output register is full
`default_nettype none

module pixel_layer_blend
    import pxb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CH_W-1:0]   base_red,
    input  wire logic [CH_W-1:0]   base_green,
    input  wire logic [CH_W-1:0]   base_blue,
    input  wire logic [CH_W-1:0]   top_red,
    input  wire logic [CH_W-1:0]   top_green,
    input  wire logic [CH_W-1:0]   top_blue,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CH_W-1:0]        out_red,
    output logic [CH_W-1:0]        out_green,
    output logic [CH_W-1:0]        out_blue,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_data
);

    blend_mode_t mode_reg;

    logic advance;

    logic [CH_W-1:0] base_ch  [NUM_CH];
    logic [CH_W-1:0] layer_ch [NUM_CH];

    logic [PROD_W-1:0]  s1_prod_next [NUM_CH];
    logic [CH_W-1:0]    s1_diff_next [NUM_CH];
    logic [NUM_CH-1:0]  s1_inv_next;
    logic [NUM_CH-1:0]  s1_dbl_next;
    logic               s1_sub_next;

    logic               s1_valid_reg;
    logic [PROD_W-1:0]  s1_prod_reg [NUM_CH];
    logic [CH_W-1:0]    s1_diff_reg [NUM_CH];
    logic [NUM_CH-1:0]  s1_inv_reg;
    logic [NUM_CH-1:0]  s1_dbl_reg;
    logic               s1_sub_reg;

    logic [PROD_W-1:0]  s2_x_next [NUM_CH];
    logic               s2_valid_reg;
    logic [PROD_W-1:0]  s2_x_reg [NUM_CH];
    logic [CH_W-1:0]    s2_diff_reg [NUM_CH];
    logic               s2_sub_reg;

    logic               s3_valid_reg;
    logic [SCALE_W-1:0] s3_prod_reg [NUM_CH];
    logic [CH_W-1:0]    s3_diff_reg [NUM_CH];
    logic               s3_sub_reg;

    logic [CH_W-1:0]    out_next [NUM_CH];
    logic               out_valid_reg;
    logic [CH_W-1:0]    out_reg [NUM_CH];

    assign base_ch[0]  = base_red;
    assign base_ch[1]  = base_green;
    assign base_ch[2]  = base_blue;
    assign layer_ch[0] = top_red;
    assign layer_ch[1] = top_green;
    assign layer_ch[2] = top_blue;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MULTIPLY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= blend_mode_t'(cfg_data);
        end
    end

    // stage 1: operand select and product
    always_comb
    begin
        logic [CH_W-1:0] op_a;
        logic [CH_W-1:0] op_b;
        s1_sub_next = (mode_reg == MODE_SUBTRACT);
        for (int c = 0; c < NUM_CH; c++)
        begin
            s1_inv_next[c] = 1'b0;
            s1_dbl_next[c] = 1'b0;
            unique case (mode_reg)
                MODE_MULTIPLY: ;
                MODE_SUBTRACT: ;
                MODE_SCREEN:   s1_inv_next[c] = 1'b1;
                MODE_OVERLAY:
                begin
                    s1_inv_next[c] = layer_ch[c][CH_W-1];
                    s1_dbl_next[c] = 1'b1;
                end
            endcase
            // 255 - v is the bitwise complement for 8-bit v
            op_a = s1_inv_next[c] ? ~base_ch[c]  : base_ch[c];
            op_b = s1_inv_next[c] ? ~layer_ch[c] : layer_ch[c];
            s1_prod_next[c] = PROD_W'(op_a) * PROD_W'(op_b);
            s1_diff_next[c] = (base_ch[c] > layer_ch[c]) ?
                              CH_W'(base_ch[c] - layer_ch[c]) : '0;
        end
    end

    // stage 2: double, complement against full scale, add rounding bias
    always_comb
    begin
        logic [PROD_W-1:0] scaled;
        logic [PROD_W-1:0] num;
        for (int c = 0; c < NUM_CH; c++)
        begin
            scaled = s1_dbl_reg[c] ? {s1_prod_reg[c][PROD_W-2:0], 1'b0} : s1_prod_reg[c];
            num = s1_inv_reg[c] ? PROD_W'(FULL_SCALE - scaled) : scaled;
            s2_x_next[c] = PROD_W'(num + ROUND_BIAS);
        end
    end

    // output select, quotient never exceeds 255
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            out_next[c] = s3_sub_reg ? s3_diff_reg[c] :
                          s3_prod_reg[c][RECIP_SHIFT +: CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_inv_reg <= s1_inv_next;
            s1_dbl_reg <= s1_dbl_next;
            s1_sub_reg <= s1_sub_next;
            s2_sub_reg <= s1_sub_reg;
            s3_sub_reg <= s2_sub_reg;
            for (int c = 0; c < NUM_CH; c++)
            begin
                s1_prod_reg[c] <= s1_prod_next[c];
                s1_diff_reg[c] <= s1_diff_next[c];
                s2_x_reg[c]    <= s2_x_next[c];
                s2_diff_reg[c] <= s1_diff_reg[c];
                s3_prod_reg[c] <= SCALE_W'(s2_x_reg[c]) * SCALE_W'(RECIP_255);
                s3_diff_reg[c] <= s2_diff_reg[c];
                out_reg[c]     <= out_next[c];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];

`ifndef SYNTHESIS
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> in_stall)
        else $error("input taken while output word is held");

    a_s1_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_valid_reg) |-> $past(in_valid && !in_stall))
        else $error("stage 1 valid without an accepted word");

    a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg))
        else $error("output valid without stage 3 word");
`endif

endmodule

`default_nettype wire

@@ verif/pixel_layer_blend_tb.sv @@
`default_nettype none

module pixel_layer_blend_tb;
    import pxb_pkg::*;

    localparam int LATENCY     = 4;
    localparam int DRAIN_WAIT  = 4 * LATENCY;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [CH_W-1:0] base_red;
    logic [CH_W-1:0] base_green;
    logic [CH_W-1:0] base_blue;
    logic [CH_W-1:0] top_red;
    logic [CH_W-1:0] top_green;
    logic [CH_W-1:0] top_blue;
    logic            out_valid;
    logic            out_stall;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [1:0]      cfg_data;

    blend_mode_t active_mode;
    rgb_t        blended_q[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          stall_pct;

    pixel_layer_blend dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .base_red   (base_red),
        .base_green (base_green),
        .base_blue  (base_blue),
        .top_red    (top_red),
        .top_green  (top_green),
        .top_blue   (top_blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic int unsigned round_div255(int unsigned num);
        return (2 * num + 255) / 510;
    endfunction

    function automatic logic [CH_W-1:0] blend_channel(logic [CH_W-1:0] base_val,
                                                      logic [CH_W-1:0] layer_val,
                                                      blend_mode_t mode);
        int unsigned b;
        int unsigned l;
        int unsigned inv;
        int unsigned r;
        b = base_val;
        l = layer_val;
        inv = (255 - b) * (255 - l);
        case (mode)
            MODE_MULTIPLY: r = round_div255(b * l);
            MODE_SUBTRACT: r = (b > l) ? b - l : 0;
            MODE_SCREEN:   r = round_div255(255 * 255 - inv);
            default:
            begin
                if (l <= 127)
                    r = round_div255(2 * b * l);
                else
                    r = round_div255(255 * 255 - 2 * inv);
            end
        endcase
        if (r > 255)
            r = 255;
        return r[CH_W-1:0];
    endfunction

    function automatic rgb_t blend_pixel(rgb_t base_px, rgb_t layer_px, blend_mode_t mode);
        rgb_t px;
        px.red   = blend_channel(base_px.red,   layer_px.red,   mode);
        px.green = blend_channel(base_px.green, layer_px.green, mode);
        px.blue  = blend_channel(base_px.blue,  layer_px.blue,  mode);
        return px;
    endfunction

    // receiver stall pattern
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (blended_q.size() == 0)
            begin
                $display("%0t unexpected word: actual %h %h %h", $time,
                         out_red, out_green, out_blue);
                error_count++;
            end
            else
            begin
                want = blended_q.pop_front();
                if (out_red !== want.red)
                begin
                    $display("%0t out_red: expected %h actual %h", $time, want.red, out_red);
                    error_count++;
                end
                if (out_green !== want.green)
                begin
                    $display("%0t out_green: expected %h actual %h", $time,
                             want.green, out_green);
                    error_count++;
                end
                if (out_blue !== want.blue)
                begin
                    $display("%0t out_blue: expected %h actual %h", $time, want.blue, out_blue);
                    error_count++;
                end
            end
        end
    end

    task automatic send_pixel(rgb_t base_px, rgb_t layer_px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid   = 1'b1;
        base_red   = base_px.red;
        base_green = base_px.green;
        base_blue  = base_px.blue;
        top_red    = layer_px.red;
        top_green  = layer_px.green;
        top_blue   = layer_px.blue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        blended_q.push_back(blend_pixel(base_px, layer_px, active_mode));
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        in_valid = 1'b0;
        while (blended_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_blend_mode(blend_mode_t mode);
        drain_pipeline();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        active_mode = mode;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_directed(int idx);
        rgb_t b;
        rgb_t l;
        case (idx)
            0:
            begin
                b = {8'd0,   8'd0,   8'd0};
                l = {8'd0,   8'd0,   8'd0};
            end
            1:
            begin
                b = {8'd255, 8'd255, 8'd255};
                l = {8'd255, 8'd255, 8'd255};
            end
            2:
            begin
                b = {8'd0,   8'd255, 8'd128};
                l = {8'd255, 8'd0,   8'd127};
            end
            3:
            begin
                b = {8'd255, 8'd0,   8'd127};
                l = {8'd128, 8'd127, 8'd255};
            end
            4:
            begin
                b = {8'd1,   8'd254, 8'd200};
                l = {8'd127, 8'd128, 8'd1};
            end
            default:
            begin
                b = {8'd128, 8'd127, 8'd64};
                l = {8'd254, 8'd1,   8'd128};
            end
        endcase
        send_pixel(b, l);
    endtask

    function automatic logic [CH_W-1:0] rand_channel();
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(5))
                0: return 8'd0;
                1: return 8'd1;
                2: return 8'd127;
                3: return 8'd128;
                4: return 8'd254;
                default: return 8'd255;
            endcase
        end
        return CH_W'($urandom_range(255));
    endfunction

    // multiply is the mode out of reset, no register write
    task automatic test_reset_mode();
        for (int i = 0; i < 6; i++)
            send_directed(i);
    endtask

    task automatic test_directed_modes();
        write_blend_mode(MODE_SUBTRACT);
        for (int i = 0; i < 6; i++)
            send_directed(i);
        write_blend_mode(MODE_SCREEN);
        for (int i = 0; i < 6; i++)
            send_directed(i);
        write_blend_mode(MODE_OVERLAY);
        for (int i = 0; i < 6; i++)
            send_directed(i);
    endtask

    task automatic test_random_stream(int idle_pct, int stall_level, int phase);
        rgb_t b;
        rgb_t l;
        send_idle_pct = idle_pct;
        stall_pct     = stall_level;
        for (int seg = 0; seg < 4; seg++)
        begin
            write_blend_mode(blend_mode_t'((phase + seg) % 4));
            for (int i = 0; i < 25; i++)
            begin
                b = {rand_channel(), rand_channel(), rand_channel()};
                l = {rand_channel(), rand_channel(), rand_channel()};
                send_pixel(b, l);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        base_red      = '0;
        base_green    = '0;
        base_blue     = '0;
        top_red       = '0;
        top_green     = '0;
        top_blue      = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = MODE_MULTIPLY;
        active_mode   = MODE_MULTIPLY;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_mode();
        test_directed_modes();
        test_random_stream(0, 0, 0);
        test_random_stream(45, 0, 1);
        test_random_stream(0, 45, 2);
        test_random_stream(9, 9, 3);

        drain_pipeline();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
